[sv/sphere_shape_collision_test_top_defines.svh]
// assertion macros for the sphere collision tester
`ifndef SPHERE_SHAPE_COLLISION_TEST_TOP_DEFINES_SVH
`define SPHERE_SHAPE_COLLISION_TEST_TOP_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define SSCT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define SSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ssct_pkg.sv]
// shared types and constants of the sphere collision tester
package ssct_pkg;

    localparam int AXIS_FRAC  = 14;
    localparam int SQRT_BITS  = 32;
    localparam int DIV_BITS   = 15;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [14:0] AXIS_ONE = 15'd16384;
    localparam logic [32:0] MAG_CAP  = 33'h1_0000_0000;

    localparam logic [1:0] MODE_SPHERE = 2'd0;
    localparam logic [1:0] MODE_AABB   = 2'd1;
    localparam logic [1:0] MODE_OBB    = 2'd2;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        r;
    } ssct_cfg_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic [2:0][31:0]       pos;
        logic [2:0][31:0]       ext;
        logic [30:0]            orad;
        logic [2:0][47:0]       axes;
        logic                   trig;
    } ssct_req_t;

    // classified item: per-axis distance magnitude (capped) and sign
    typedef struct packed {
        logic [2:0][32:0] mag;
        logic [2:0]       neg;
        logic [31:0]      radius;
        logic             ok;
        logic             trig;
    } ssct_item_t;

    typedef struct packed {
        logic             hit;
        logic             trig;
        logic [2:0][15:0] axis;
        logic [31:0]      overlap;
    } ssct_res_t;

endpackage

[sv/ssct_front.sv]
// front pipeline: per-mode closest point and distance vector
module ssct_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssct_pkg::ssct_cfg_t  cfg,
    input  ssct_pkg::ssct_req_t  req,
    input  logic              req_valid,
    output logic              req_ready,
    output ssct_pkg::ssct_item_t item,
    output logic              item_valid,
    input  logic              item_ready
);
    import ssct_pkg::*;

    logic [4:0] vld_reg;
    logic       adv;

    logic signed [31:0] own [3];
    logic signed [32:0] rel_c [3];
    logic signed [31:0] clp_c [3];
    logic signed [32:0] d01_c [3];
    logic [31:0]        rad_c;

    logic signed [32:0] s1_rel_reg [3];
    logic signed [15:0] s1_a_reg [3][3];
    logic signed [31:0] s1_e_reg [3];
    logic signed [32:0] s1_d01_reg [3];
    logic [31:0]        s1_rad_reg;
    logic [1:0]         s1_mode_reg;
    logic               s1_trig_reg;

    logic signed [48:0] s2_pr_reg [3][3];
    logic signed [15:0] s2_a_reg [3][3];
    logic signed [31:0] s2_e_reg [3];
    logic signed [32:0] s2_rel_reg [3];
    logic signed [32:0] s2_d01_reg [3];
    logic [31:0]        s2_rad_reg;
    logic [1:0]         s2_mode_reg;
    logic               s2_trig_reg;

    logic signed [50:0] psum_c [3];
    logic signed [36:0] proj_c [3];
    logic signed [32:0] lo_c [3];
    logic signed [32:0] hi_c [3];
    logic signed [33:0] c_c [3];

    logic signed [33:0] s3_c_reg [3];
    logic signed [15:0] s3_a_reg [3][3];
    logic signed [32:0] s3_rel_reg [3];
    logic signed [32:0] s3_d01_reg [3];
    logic [31:0]        s3_rad_reg;
    logic [1:0]         s3_mode_reg;
    logic               s3_trig_reg;

    logic signed [49:0] s4_q_reg [3][3];
    logic signed [32:0] s4_rel_reg [3];
    logic signed [32:0] s4_d01_reg [3];
    logic [31:0]        s4_rad_reg;
    logic [1:0]         s4_mode_reg;
    logic               s4_trig_reg;

    logic signed [51:0] off_c [3];
    logic signed [37:0] fs_c [3];
    logic signed [38:0] d_c [3];
    logic [38:0]        abs_c [3];
    ssct_item_t         item_c;
    ssct_item_t         item_reg;

    assign adv        = !vld_reg[4] || item_ready;
    assign req_ready  = adv;
    assign item_valid = vld_reg[4];
    assign item       = item_reg;

    assign own[0] = cfg.cx;
    assign own[1] = cfg.cy;
    assign own[2] = cfg.cz;

    // relative vector, sphere offset and axis-aligned clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rel_c[i] = {own[i][31], own[i]} - {req.pos[i][31], req.pos[i]};
            if (own[i] < $signed(req.pos[i])) begin
                clp_c[i] = $signed(req.pos[i]);
            end else if (own[i] > $signed(req.ext[i])) begin
                clp_c[i] = $signed(req.ext[i]);
            end else begin
                clp_c[i] = own[i];
            end
            if (req.mode == MODE_SPHERE) begin
                d01_c[i] = {req.pos[i][31], req.pos[i]} - {own[i][31], own[i]};
            end else begin
                d01_c[i] = {clp_c[i][31], clp_c[i]} - {own[i][31], own[i]};
            end
        end
        if (req.mode == MODE_SPHERE) begin
            rad_c = {1'b0, cfg.r} + {1'b0, req.orad};
        end else begin
            rad_c = {1'b0, cfg.r};
        end
    end

    // projection onto box axes, floor shift, clamp to the half extent
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            psum_c[k] = s2_pr_reg[k][0] + s2_pr_reg[k][1] + s2_pr_reg[k][2];
            proj_c[k] = psum_c[k][50:AXIS_FRAC];
            hi_c[k]   = s2_e_reg[k];
            lo_c[k]   = 33'sd0 - hi_c[k];
            if (proj_c[k] < lo_c[k]) begin
                c_c[k] = lo_c[k];
            end else if (proj_c[k] > hi_c[k]) begin
                c_c[k] = hi_c[k];
            end else begin
                c_c[k] = proj_c[k][33:0];
            end
        end
    end

    // back to world offset, pick the mode result, split sign and magnitude
    always_comb begin
        item_c = '0;
        for (int i = 0; i < 3; i++) begin
            off_c[i] = s4_q_reg[0][i] + s4_q_reg[1][i] + s4_q_reg[2][i];
            fs_c[i]  = off_c[i][51:AXIS_FRAC];
            if (s4_mode_reg == MODE_OBB) begin
                d_c[i] = fs_c[i] - s4_rel_reg[i];
            end else begin
                d_c[i] = s4_d01_reg[i];
            end
            abs_c[i] = d_c[i][38] ? -d_c[i] : d_c[i];
            item_c.neg[i] = d_c[i][38];
            // anything at or past 2^32 can never hit
            item_c.mag[i] = (abs_c[i] > 39'(MAG_CAP)) ? MAG_CAP : abs_c[i][32:0];
        end
        item_c.radius = s4_rad_reg;
        item_c.ok     = (s4_mode_reg == MODE_SPHERE) || (s4_mode_reg == MODE_AABB)
                        || (s4_mode_reg == MODE_OBB);
        item_c.trig   = s4_trig_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], req_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s1_rel_reg[i] <= rel_c[i];
                s1_e_reg[i]   <= $signed(req.ext[i]);
                s1_d01_reg[i] <= d01_c[i];
                for (int k = 0; k < 3; k++) begin
                    s1_a_reg[k][i] <= $signed(req.axes[k][16*i +: 16]);
                end
            end
            s1_rad_reg  <= rad_c;
            s1_mode_reg <= req.mode;
            s1_trig_reg <= req.trig;

            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    s2_pr_reg[k][i] <= s1_rel_reg[i] * s1_a_reg[k][i];
                    s2_a_reg[k][i]  <= s1_a_reg[k][i];
                end
                s2_e_reg[k]   <= s1_e_reg[k];
                s2_rel_reg[k] <= s1_rel_reg[k];
                s2_d01_reg[k] <= s1_d01_reg[k];
            end
            s2_rad_reg  <= s1_rad_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_trig_reg <= s1_trig_reg;

            for (int k = 0; k < 3; k++) begin
                s3_c_reg[k]   <= c_c[k];
                s3_rel_reg[k] <= s2_rel_reg[k];
                s3_d01_reg[k] <= s2_d01_reg[k];
                for (int i = 0; i < 3; i++) begin
                    s3_a_reg[k][i] <= s2_a_reg[k][i];
                end
            end
            s3_rad_reg  <= s2_rad_reg;
            s3_mode_reg <= s2_mode_reg;
            s3_trig_reg <= s2_trig_reg;

            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    s4_q_reg[k][i] <= s3_a_reg[k][i] * s3_c_reg[k];
                end
                s4_rel_reg[k] <= s3_rel_reg[k];
                s4_d01_reg[k] <= s3_d01_reg[k];
            end
            s4_rad_reg  <= s3_rad_reg;
            s4_mode_reg <= s3_mode_reg;
            s4_trig_reg <= s3_trig_reg;

            item_reg <= item_c;
        end
    end

endmodule

[sv/ssct_fifo.sv]
// short queue of classified words between front and back
module ssct_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ssct_pkg::ssct_item_t push_data,
    input  logic                 push_valid,
    output logic                 push_ready,
    output ssct_pkg::ssct_item_t pop_data,
    output logic                 pop_valid,
    input  logic                 pop_ready
);
    import ssct_pkg::*;

    ssct_item_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = cnt_reg != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/ssct_back.sv]
// back pipeline: squared distance test, square root, axis divide, overlap
module ssct_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ssct_pkg::ssct_item_t in_item,
    input  logic                 in_valid,
    output logic                 in_ready,
    output ssct_pkg::ssct_res_t  res,
    output logic                 res_valid,
    input  logic                 res_ready
);
    import ssct_pkg::*;

    logic adv;

    logic [64:0]  b1_sq_reg [3];
    logic [63:0]  b1_rsq_reg;
    ssct_item_t   b1_item_reg;
    logic         b1_v_reg;
    logic [66:0]  dsq_c;

    logic [63:0]  sq_rem_reg  [SQRT_BITS+1];
    logic [31:0]  sq_root_reg [SQRT_BITS+1];
    logic         sq_hit_reg  [SQRT_BITS+1];
    ssct_item_t   sq_item_reg [SQRT_BITS+1];
    logic         sq_v_reg    [SQRT_BITS+1];

    logic [46:0]  dv_rem_reg  [DIV_BITS+1][3];
    logic [14:0]  dv_q_reg    [DIV_BITS+1][3];
    logic [31:0]  dv_len_reg  [DIV_BITS+1];
    logic         dv_hit_reg  [DIV_BITS+1];
    ssct_item_t   dv_item_reg [DIV_BITS+1];
    logic         dv_v_reg    [DIV_BITS+1];

    ssct_res_t    res_c;
    ssct_res_t    out_res_reg;
    logic         out_v_reg;
    logic [14:0]  qc;

    assign adv       = !out_v_reg || res_ready;
    assign in_ready  = adv;
    assign res       = out_res_reg;
    assign res_valid = out_v_reg;

    assign dsq_c = {2'b00, b1_sq_reg[0]} + {2'b00, b1_sq_reg[1]} + {2'b00, b1_sq_reg[2]};

    // squares, then sum and compare into the root pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                b1_sq_reg[i] <= 65'(in_item.mag[i] * in_item.mag[i]);
            end
            b1_rsq_reg  <= in_item.radius * in_item.radius;
            b1_item_reg <= in_item;

            sq_rem_reg[0]  <= dsq_c[63:0];
            sq_root_reg[0] <= '0;
            sq_hit_reg[0]  <= b1_item_reg.ok && (dsq_c < {3'b000, b1_rsq_reg});
            sq_item_reg[0] <= b1_item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg    <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end else if (adv) begin
            b1_v_reg    <= in_valid;
            sq_v_reg[0] <= b1_v_reg;
        end
    end

    // one result bit per stage, msb first
    for (genvar s = 0; s < SQRT_BITS; s++) begin : g_sqrt
        localparam int B = SQRT_BITS - 1 - s;
        logic [63:0] term;
        logic        take;

        assign term = (64'(sq_root_reg[s]) << (B + 1)) | (64'd1 << (2 * B));
        assign take = sq_rem_reg[s] >= term;

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[s+1]  <= take ? sq_rem_reg[s] - term : sq_rem_reg[s];
                sq_root_reg[s+1] <= take ? (sq_root_reg[s] | (32'd1 << B)) : sq_root_reg[s];
                sq_hit_reg[s+1]  <= sq_hit_reg[s];
                sq_item_reg[s+1] <= sq_item_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[s+1] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[s+1] <= sq_v_reg[s];
            end
        end
    end

    // divider entry: numerator is |d| scaled to the axis format
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= 47'(sq_item_reg[SQRT_BITS].mag[i]) << AXIS_FRAC;
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0]  <= sq_root_reg[SQRT_BITS];
            dv_hit_reg[0]  <= sq_hit_reg[SQRT_BITS];
            dv_item_reg[0] <= sq_item_reg[SQRT_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= sq_v_reg[SQRT_BITS];
        end
    end

    // restoring divide, three lanes sharing the divisor
    for (genvar t = 0; t < DIV_BITS; t++) begin : g_div
        localparam int K = DIV_BITS - 1 - t;
        logic [46:0] dsh;

        assign dsh = 47'(dv_len_reg[t]) << K;

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_rem_reg[t][i] >= dsh) begin
                        dv_rem_reg[t+1][i] <= dv_rem_reg[t][i] - dsh;
                        dv_q_reg[t+1][i]   <= dv_q_reg[t][i] | (15'd1 << K);
                    end else begin
                        dv_rem_reg[t+1][i] <= dv_rem_reg[t][i];
                        dv_q_reg[t+1][i]   <= dv_q_reg[t][i];
                    end
                end
                dv_len_reg[t+1]  <= dv_len_reg[t];
                dv_hit_reg[t+1]  <= dv_hit_reg[t];
                dv_item_reg[t+1] <= dv_item_reg[t];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[t+1] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[t+1] <= dv_v_reg[t];
            end
        end
    end

    always_comb begin
        res_c      = '0;
        qc         = '0;
        res_c.hit  = dv_hit_reg[DIV_BITS];
        res_c.trig = dv_item_reg[DIV_BITS].trig;
        for (int i = 0; i < 3; i++) begin
            qc = (dv_q_reg[DIV_BITS][i] > AXIS_ONE) ? AXIS_ONE : dv_q_reg[DIV_BITS][i];
            // zero-length axis stays the zero vector
            if (dv_hit_reg[DIV_BITS] && (dv_len_reg[DIV_BITS] != '0)) begin
                res_c.axis[i] = dv_item_reg[DIV_BITS].neg[i] ? -{1'b0, qc} : {1'b0, qc};
            end
        end
        if (dv_hit_reg[DIV_BITS]) begin
            res_c.overlap = dv_item_reg[DIV_BITS].radius - dv_len_reg[DIV_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= res_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= dv_v_reg[DIV_BITS];
        end
    end

endmodule

[sv/sphere_shape_collision_test_top.sv]
// top level of the sphere collision tester
// Tests the configured sphere against one sphere, axis-aligned box or oriented
// box per word and returns hit, trigger copy, unit axis and overlap. It takes
// one word every clock cycle while m_ready stays high. Each word passes
// through the 5-stage front (projection multiplies, clamp, back-rotation),
// the 4-deep queue, and the back part: square and compare, a 32-stage square
// root that resolves one bit per stage, and a 15-stage divider forming the
// axis. Configuration registers must only be written while no word is in flight.
`include "sphere_shape_collision_test_top_defines.svh"

module sphere_shape_collision_test_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_ext_x,
    input  logic signed [31:0] s_ext_y,
    input  logic signed [31:0] s_ext_z,
    input  logic [30:0]        s_other_radius,
    input  logic [47:0]        s_box_axis0,
    input  logic [47:0]        s_box_axis1,
    input  logic [47:0]        s_box_axis2,
    input  logic               s_other_trigger,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic               m_is_trigger,
    output logic signed [15:0] m_axis_x,
    output logic signed [15:0] m_axis_y,
    output logic signed [15:0] m_axis_z,
    output logic [31:0]        m_overlap
);
    import ssct_pkg::*;

    ssct_cfg_t  cfg_reg;
    ssct_req_t  req;
    ssct_item_t front_item;
    logic       front_valid;
    logic       fifo_ready;
    ssct_item_t fifo_item;
    logic       fifo_valid;
    logic       back_ready;
    ssct_res_t  res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CENTER_X: begin
                    cfg_reg.cx <= cfg_wdata;
                end
                REG_CENTER_Y: begin
                    cfg_reg.cy <= cfg_wdata;
                end
                REG_CENTER_Z: begin
                    cfg_reg.cz <= cfg_wdata;
                end
                REG_RADIUS: begin
                    cfg_reg.r <= cfg_wdata[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign req.mode    = s_mode;
    assign req.pos[0]  = s_pos_x;
    assign req.pos[1]  = s_pos_y;
    assign req.pos[2]  = s_pos_z;
    assign req.ext[0]  = s_ext_x;
    assign req.ext[1]  = s_ext_y;
    assign req.ext[2]  = s_ext_z;
    assign req.orad    = s_other_radius;
    assign req.axes[0] = s_box_axis0;
    assign req.axes[1] = s_box_axis1;
    assign req.axes[2] = s_box_axis2;
    assign req.trig    = s_other_trigger;

    ssct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .req        (req),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (fifo_ready)
    );

    ssct_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (front_item),
        .push_valid (front_valid),
        .push_ready (fifo_ready),
        .pop_data   (fifo_item),
        .pop_valid  (fifo_valid),
        .pop_ready  (back_ready)
    );

    ssct_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (fifo_item),
        .in_valid  (fifo_valid),
        .in_ready  (back_ready),
        .res       (res),
        .res_valid (m_valid),
        .res_ready (m_ready)
    );

    assign m_hit        = res.hit;
    assign m_is_trigger = res.trig;
    assign m_axis_x     = $signed(res.axis[0]);
    assign m_axis_y     = $signed(res.axis[1]);
    assign m_axis_z     = $signed(res.axis[2]);
    assign m_overlap    = res.overlap;

    `SSCT_ASSERT_IMPL(a_miss_zero, m_valid && !m_hit, (m_overlap == 32'd0) && (m_axis_x == 16'sd0) && (m_axis_y == 16'sd0) && (m_axis_z == 16'sd0), "miss with nonzero axis or overlap")
    `SSCT_ASSERT_IMPL(a_axis_unit, m_valid && m_hit, (m_axis_x <= 16'sd16384) && (m_axis_x >= -16'sd16384) && (m_axis_y <= 16'sd16384) && (m_axis_y >= -16'sd16384) && (m_axis_z <= 16'sd16384) && (m_axis_z >= -16'sd16384), "axis component out of unit range")
    `SSCT_ASSERT_NEXT(a_queue_keeps, front_valid && fifo_ready && !(fifo_valid && back_ready), fifo_valid, "queued word lost")

endmodule
